[design/ubt_pkg.sv]
// Shared types, constants and classing functions for the UTF-8 break-unit tokeniser.
package ubt_pkg;

  // Codepoint classes as carried on char_class
  typedef enum logic [1:0] {
    CLASS_SPACE   = 2'd0,
    CLASS_NEWLINE = 2'd1,
    CLASS_CJK     = 2'd2,
    CLASS_WORD    = 2'd3
  } char_class_t;

  localparam int unsigned CP_W     = 21;
  localparam int unsigned COUNT_W  = 3;
  localparam int unsigned PEND_W   = 2;

  // Lead byte payload masks
  localparam logic [7:0] LEAD2_MASK = 8'h1F;
  localparam logic [7:0] LEAD3_MASK = 8'h0F;
  localparam logic [7:0] LEAD4_MASK = 8'h07;
  localparam logic [7:0] CONT_MASK  = 8'h3F;

  localparam logic [CP_W-1:0] CP_TAB     = 21'h00009;
  localparam logic [CP_W-1:0] CP_NEWLINE = 21'h0000A;
  localparam logic [CP_W-1:0] CP_SPACE   = 21'h00020;

  // CJK ranges, inclusive
  localparam logic [CP_W-1:0] CJK_A_LO = 21'h02E80;
  localparam logic [CP_W-1:0] CJK_A_HI = 21'h09FFF;
  localparam logic [CP_W-1:0] CJK_B_LO = 21'h0AC00;
  localparam logic [CP_W-1:0] CJK_B_HI = 21'h0D7AF;
  localparam logic [CP_W-1:0] CJK_C_LO = 21'h0F900;
  localparam logic [CP_W-1:0] CJK_C_HI = 21'h0FAFF;
  localparam logic [CP_W-1:0] CJK_D_LO = 21'h0FF00;
  localparam logic [CP_W-1:0] CJK_D_HI = 21'h0FFEF;
  localparam logic [CP_W-1:0] CJK_E_LO = 21'h20000;
  localparam logic [CP_W-1:0] CJK_E_HI = 21'h2FA1F;

  function automatic logic is_cjk(input logic [CP_W-1:0] cp);
    return (cp >= CJK_A_LO && cp <= CJK_A_HI) ||
           (cp >= CJK_B_LO && cp <= CJK_B_HI) ||
           (cp >= CJK_C_LO && cp <= CJK_C_HI) ||
           (cp >= CJK_D_LO && cp <= CJK_D_HI) ||
           (cp >= CJK_E_LO && cp <= CJK_E_HI);
  endfunction

  function automatic char_class_t class_of(input logic [CP_W-1:0] cp);
    char_class_t cls;
    if (cp == CP_SPACE || cp == CP_TAB) begin
      cls = CLASS_SPACE;
    end else if (cp == CP_NEWLINE) begin
      cls = CLASS_NEWLINE;
    end else if (is_cjk(cp)) begin
      cls = CLASS_CJK;
    end else begin
      cls = CLASS_WORD;
    end
    return cls;
  endfunction

endpackage

[design/utf8_break_unit_tokeniser_core.sv]
// UTF-8 break-unit tokeniser: lenient decoder, classer and break-unit marker.
//
// Takes one text byte per transfer and decodes lenient UTF-8: a lead byte
// (110xxxxx, 1110xxxx, 11110xxx) opens a 2, 3 or 4 byte sequence and the
// following bytes are absorbed as continuation bytes without checking, each
// adding its low six bits. Any other byte is a one-byte codepoint equal to
// itself. A lead byte or a mid-sequence byte gives no result; the byte that
// completes a sequence gives one. A byte flagged end_of_text always gives a
// result with text_done set, carrying the partial value and the true byte
// count if the sequence was cut short, and all decoder state plus the open
// word flag then return to zero so the next byte starts a fresh text.
// Each codepoint is classed as space/tab, newline, CJK or word character;
// begins_unit is set on every non-word codepoint and on the first word
// character of a run. Throughput is one byte per cycle unless the result
// channel stalls: the decode, class range compares and word tracking sit in
// one combinational pass from the input ports to a single result register,
// and a new byte is taken whenever that register is empty or being emptied
// in the same cycle. Results are registered. No clearing pass after reset.
module utf8_break_unit_tokeniser_core (
  input  logic        clk,
  input  logic        rst,
  // byte input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  text_byte,
  input  logic        end_of_text,
  // codepoint result channel
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] codepoint,
  output logic [2:0]  byte_count,
  output logic [1:0]  char_class,
  output logic        begins_unit,
  output logic        text_done
);

  // decoder state
  logic [ubt_pkg::CP_W-1:0]    partial_value, partial_value_next;
  logic [ubt_pkg::PEND_W-1:0]  bytes_pending, bytes_pending_next;
  logic [ubt_pkg::COUNT_W-1:0] sequence_length, sequence_length_next;
  logic                        word_open, word_open_next;

  // result register
  logic                        out_valid_next;

  // per-byte decode
  logic                        in_fire;
  logic                        emit;
  logic [ubt_pkg::CP_W-1:0]    emit_cp;
  logic [ubt_pkg::COUNT_W-1:0] emit_count;
  ubt_pkg::char_class_t        emit_class;
  logic                        emit_begins;
  logic [ubt_pkg::CP_W-1:0]    cont_value;
  logic [ubt_pkg::PEND_W-1:0]  pend_dec;
  logic [ubt_pkg::CP_W-1:0]    lead_cp;
  logic [ubt_pkg::COUNT_W-1:0] lead_len;
  logic                        is_lead;

  // Result register is the skid: take a byte whenever it is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;

  // Lead byte recognition
  always_comb begin
    is_lead  = 1'b1;
    lead_cp  = '0;
    lead_len = 3'd1;
    if (text_byte[7:5] == 3'b110) begin
      lead_cp  = {13'd0, text_byte & ubt_pkg::LEAD2_MASK};
      lead_len = 3'd2;
    end else if (text_byte[7:4] == 4'b1110) begin
      lead_cp  = {13'd0, text_byte & ubt_pkg::LEAD3_MASK};
      lead_len = 3'd3;
    end else if (text_byte[7:3] == 5'b11110) begin
      lead_cp  = {13'd0, text_byte & ubt_pkg::LEAD4_MASK};
      lead_len = 3'd4;
    end else begin
      is_lead  = 1'b0;
    end
  end

  // Continuation: shift in six bits, the top of the value falls off
  assign cont_value = {partial_value[ubt_pkg::CP_W-7:0], text_byte[5:0]};
  assign pend_dec   = bytes_pending - 2'd1;

  // Decoder step and result selection
  always_comb begin
    emit                 = 1'b0;
    emit_cp              = '0;
    emit_count           = 3'd1;
    partial_value_next   = partial_value;
    bytes_pending_next   = bytes_pending;
    sequence_length_next = sequence_length;
    if (bytes_pending == '0) begin
      if (!is_lead) begin
        // ASCII, stray continuation or invalid lead: one-byte codepoint
        emit    = 1'b1;
        emit_cp = {13'd0, text_byte};
      end else if (end_of_text) begin
        // lead byte cut off by end of text
        emit    = 1'b1;
        emit_cp = lead_cp;
      end else begin
        partial_value_next   = lead_cp;
        sequence_length_next = lead_len;
        bytes_pending_next   = ubt_pkg::PEND_W'(lead_len - 3'd1);
      end
    end else begin
      partial_value_next = cont_value;
      bytes_pending_next = pend_dec;
      if (pend_dec == '0 || end_of_text) begin
        emit       = 1'b1;
        emit_cp    = cont_value;
        emit_count = sequence_length - {1'b0, pend_dec};
      end
    end
    // any result returns the decoder to idle
    if (emit) begin
      partial_value_next   = '0;
      bytes_pending_next   = '0;
      sequence_length_next = '0;
    end
  end

  // Classing and word tracking
  always_comb begin
    emit_class     = ubt_pkg::class_of(emit_cp);
    emit_begins    = 1'b1;
    word_open_next = word_open;
    if (emit) begin
      if (emit_class == ubt_pkg::CLASS_WORD) begin
        emit_begins    = !word_open;
        word_open_next = 1'b1;
      end else begin
        word_open_next = 1'b0;
      end
      if (end_of_text) begin
        word_open_next = 1'b0;
      end
    end
  end

  always_comb begin
    if (in_fire && emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_pending   <= '0;
      sequence_length <= '0;
      word_open       <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      if (in_fire) begin
        partial_value   <= partial_value_next;
        bytes_pending   <= bytes_pending_next;
        sequence_length <= sequence_length_next;
        word_open       <= word_open_next;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      codepoint   <= emit_cp;
      byte_count  <= emit_count;
      char_class  <= emit_class;
      begins_unit <= emit_begins;
      text_done   <= end_of_text;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (byte_count != 3'd0 && byte_count <= 3'd4))
    else $error("byte_count out of range");

  a_non_word_begins: assert property (@(posedge clk) disable iff (rst)
    (out_valid && char_class != ubt_pkg::CLASS_WORD) |-> begins_unit)
    else $error("non-word codepoint without begins_unit");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (in_fire && end_of_text) |=> (!word_open && bytes_pending == '0 && out_valid && text_done))
    else $error("end of text did not flush state");

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    (bytes_pending != '0) |-> ({1'b0, bytes_pending} < sequence_length))
    else $error("pending bytes exceed sequence length");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule
